// ----- rtl/core/uts_pkg.sv -----
// Package for the time offset sync receiver: frame constants, event codes,
// the front-to-back queue entry type and default parameter values. No dependencies.
package uts_pkg;

   localparam int unsigned DefaultQueueDepth = 2;

   localparam logic [31:0] MAGIC_WORD        = 32'h5453_594E;  // "TSYN"
   localparam logic [7:0]  TYPE_MARKER       = 8'd10;
   localparam logic [7:0]  TYPE_REQUEST      = 8'd20;
   localparam logic [15:0] REQUEST_LEN       = 16'd8;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd32;
   localparam logic [2:0]  HEADER_LAST       = 3'd7;

   typedef enum logic [2:0] {
      EV_MARKER      = 3'd0,
      EV_OFFSET      = 3'd1,
      EV_BAD_MAGIC   = 3'd2,
      EV_TOO_LONG    = 3'd3,
      EV_OTHER       = 3'd4,
      EV_BAD_REQUEST = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      FK_BAD_MAGIC = 2'd0,
      FK_TOO_LONG  = 2'd1,
      FK_FINISH    = 2'd2
   } frame_kind_type;

   // One classified frame, handed from the parser to the sync logic.
   typedef struct packed {
      frame_kind_type kind;
      logic           is_marker;   // type is the marker type
      logic           is_request;  // type is the request type with the request length
      logic [7:0]     seq;
      logic [63:0]    start_time;  // t2 candidate: stamp of the first header byte
      logic [63:0]    t1;          // last eight payload bytes, little-endian
   } frame_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- rtl/core/uts_if.sv -----
// Channel interfaces for the time offset sync receiver: request and response.
// Depends on nothing.
interface uts_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [63:0] byte_time_us;

   modport source (output valid, output rx_byte, output byte_time_us, input ready);
   modport sink   (input valid, input rx_byte, input byte_time_us, output ready);
endinterface

interface uts_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  frame_seq;
   logic [63:0] offset_us;
   logic        synced;

   modport source (output valid, output event_res, output frame_seq, output offset_us,
                   output synced, input ready);
   modport sink   (input valid, input event_res, input frame_seq, input offset_us,
                   input synced, output ready);
endinterface

// ----- rtl/core/uts_front.sv -----
// Byte parser: assembles headers, counts payload and pushes classified frames.
// Depends on uts_pkg.
module uts_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [15:0]              csr_wdata,
   input  logic                     accept,
   input  logic [7:0]               rx_byte,
   input  logic [63:0]              byte_time_us,
   output logic                     push,
   output uts_pkg::frame_entry_type push_entry
);
   import uts_pkg::*;

   logic [15:0] max_payload_ff, max_payload_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [63:0] header_shift_ff, header_shift_in;
   logic        in_payload_ff, in_payload_in;
   logic [15:0] payload_left_ff, payload_left_in;
   logic [63:0] payload_value_ff, payload_value_in;
   logic [63:0] start_time_ff, start_time_in;

   logic [63:0] hs_new;
   logic [15:0] len_new;
   logic [15:0] len_cur;
   logic [63:0] pv_shift;

   assign hs_new   = {header_shift_ff[55:0], rx_byte};
   assign len_new  = {hs_new[15:8], hs_new[23:16]};
   assign len_cur  = {header_shift_ff[15:8], header_shift_ff[23:16]};
   assign pv_shift = {rx_byte, payload_value_ff[63:8]};

   always_comb begin
      max_payload_in   = csr_we ? csr_wdata : max_payload_ff;
      header_count_in  = header_count_ff;
      header_shift_in  = header_shift_ff;
      in_payload_in    = in_payload_ff;
      payload_left_in  = payload_left_ff;
      payload_value_in = payload_value_ff;
      start_time_in    = start_time_ff;
      push             = 1'b0;
      push_entry.kind       = FK_FINISH;
      push_entry.is_marker  = header_shift_ff[31:24] == TYPE_MARKER;
      push_entry.is_request = header_shift_ff[31:24] == TYPE_REQUEST && len_cur == REQUEST_LEN;
      push_entry.seq        = header_shift_ff[7:0];
      push_entry.start_time = start_time_ff;
      push_entry.t1         = pv_shift;

      if (accept) begin
         if (in_payload_ff) begin
            payload_value_in = pv_shift;
            payload_left_in  = payload_left_ff - 16'd1;
            if (payload_left_ff == 16'd1) begin
               in_payload_in = 1'b0;
               push          = 1'b1;
            end
         end else begin
            if (header_count_ff == 3'd0) begin
               start_time_in = byte_time_us;
            end
            header_shift_in = hs_new;
            push_entry.is_marker  = hs_new[31:24] == TYPE_MARKER;
            push_entry.is_request = hs_new[31:24] == TYPE_REQUEST && len_new == REQUEST_LEN;
            push_entry.seq        = hs_new[7:0];
            push_entry.t1         = '0;
            if (header_count_ff != HEADER_LAST) begin
               header_count_in = header_count_ff + 3'd1;
            end else begin
               header_count_in = 3'd0;
               if (hs_new[63:32] != MAGIC_WORD) begin
                  push            = 1'b1;
                  push_entry.kind = FK_BAD_MAGIC;
               end else if (len_new > max_payload_ff) begin
                  push            = 1'b1;
                  push_entry.kind = FK_TOO_LONG;
               end else begin
                  payload_value_in = '0;
                  if (len_new == 16'd0) begin
                     push = 1'b1;
                  end else begin
                     in_payload_in   = 1'b1;
                     payload_left_in = len_new;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff  <= MAX_PAYLOAD_RESET;
         header_count_ff <= 3'd0;
         in_payload_ff   <= 1'b0;
      end else begin
         max_payload_ff  <= max_payload_in;
         header_count_ff <= header_count_in;
         in_payload_ff   <= in_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      header_shift_ff  <= header_shift_in;
      payload_left_ff  <= payload_left_in;
      payload_value_ff <= payload_value_in;
      start_time_ff    <= start_time_in;
   end

endmodule

// ----- rtl/core/uts_queue.sv -----
// Short register queue of classified frames between the parser and the sync logic.
// Depends on uts_pkg.
module uts_queue #(
   parameter int unsigned DEPTH = uts_pkg::DefaultQueueDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  uts_pkg::frame_entry_type  push_entry,
   input  logic                      pop,
   output uts_pkg::frame_entry_type  head_entry,
   output uts_pkg::queue_status_type status
);
   import uts_pkg::*;

   localparam int unsigned PtrW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   frame_entry_type slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full  = count_ff == CntFull;
   assign status.empty = count_ff == '0;
   assign head_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count beyond depth");

endmodule

// ----- rtl/core/uts_back.sv -----
// Sync logic: marker/request pairing, offset computation and the response register.
// Depends on uts_pkg.
module uts_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     entry_valid,
   input  uts_pkg::frame_entry_type entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_event_res,
   output logic [7:0]               rsp_frame_seq,
   output logic [63:0]              rsp_offset_us,
   output logic                     rsp_synced
);
   import uts_pkg::*;

   logic        awaiting_ff, awaiting_in;
   logic [63:0] marker_time_ff, marker_time_in;
   logic [7:0]  marker_seq_ff, marker_seq_in;
   logic [63:0] offset_ff, offset_in;
   logic        synced_ff, synced_in;
   logic        out_valid_ff, out_valid_in;
   event_type   out_event_ff, out_event_in;
   logic [7:0]  out_seq_ff, out_seq_in;

   assign pop = entry_valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      awaiting_in    = awaiting_ff;
      marker_time_in = marker_time_ff;
      marker_seq_in  = marker_seq_ff;
      offset_in      = offset_ff;
      synced_in      = synced_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_event_in   = out_event_ff;
      out_seq_in     = out_seq_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         out_seq_in   = entry.seq;
         case (entry.kind)
            FK_BAD_MAGIC: begin
               awaiting_in  = 1'b0;
               out_event_in = EV_BAD_MAGIC;
            end
            FK_TOO_LONG: begin
               awaiting_in  = 1'b0;
               out_event_in = EV_TOO_LONG;
            end
            FK_FINISH: begin
               if (!awaiting_ff) begin
                  if (entry.is_marker) begin
                     marker_time_in = entry.start_time;
                     marker_seq_in  = entry.seq;
                     awaiting_in    = 1'b1;
                     out_event_in   = EV_MARKER;
                  end else begin
                     out_event_in = EV_OTHER;
                  end
               end else begin
                  awaiting_in = 1'b0;
                  if (entry.is_request && entry.seq == marker_seq_ff) begin
                     offset_in    = marker_time_ff - entry.t1;
                     synced_in    = 1'b1;
                     out_event_in = EV_OFFSET;
                  end else begin
                     out_event_in = EV_BAD_REQUEST;
                  end
               end
            end
            default: begin
               out_event_in = EV_OTHER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff    <= 1'b0;
         marker_time_ff <= '0;
         marker_seq_ff  <= '0;
         offset_ff      <= '0;
         synced_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         awaiting_ff    <= awaiting_in;
         marker_time_ff <= marker_time_in;
         marker_seq_ff  <= marker_seq_in;
         offset_ff      <= offset_in;
         synced_ff      <= synced_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_event_ff <= out_event_in;
      out_seq_ff   <= out_seq_in;
   end

   // The offset and synced flag always reflect the state after the reported frame.
   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = out_event_ff;
   assign rsp_frame_seq = out_seq_ff;
   assign rsp_offset_us = offset_ff;
   assign rsp_synced    = synced_ff;

   a_synced_sticky: assert property (@(posedge clock) disable iff (reset)
      synced_ff |=> synced_ff)
      else $error("synced flag dropped");
   a_offset_implies_synced: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_event_ff == EV_OFFSET |-> synced_ff)
      else $error("offset event without synced flag");
   a_pop_gives_response: assert property (@(posedge clock) disable iff (reset)
      pop |=> out_valid_ff)
      else $error("popped frame produced no response");

endmodule

// ----- rtl/core/uart_time_offset_sync_receiver.sv -----
// A response to the request that ends a frame passes through a frame queue slot and then
// the response register, and comes later when frames queue up behind a stalled response
// channel. Throughput: one request per cycle while the frame queue is not full; at most
// one response per cycle, drained from a DEPTH-entry frame queue between the byte
// parser and the sync logic.
// Reset (synchronous, active high) clears all control state, the offset, synced flag,
// and restores max_payload to 32.
//
// Depends on uts_pkg and the uts_req_if / uts_rsp_if interfaces.
module uart_time_offset_sync_receiver #(
   parameter int unsigned QUEUE_DEPTH = uts_pkg::DefaultQueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   uts_req_if.sink     req_chan,
   uts_rsp_if.source   rsp_chan
);
   import uts_pkg::*;

   logic             req_accept;
   logic             push;
   frame_entry_type  push_entry;
   frame_entry_type  head_entry;
   queue_status_type q_status;
   logic             pop;

   // The parser takes a byte whenever the queue has room for the frame it might finish.
   assign req_chan.ready = !q_status.full;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Front: header assembly, payload counting and frame classification.
   uts_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .accept       (req_accept),
      .rx_byte      (req_chan.rx_byte),
      .byte_time_us (req_chan.byte_time_us),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Queue of finished frames so the parser keeps taking bytes while a response waits.
   uts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // Back: marker/request pairing, offset subtract and the response register.
   uts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (!q_status.empty),
      .entry         (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_event_res (rsp_chan.event_res),
      .rsp_frame_seq (rsp_chan.frame_seq),
      .rsp_offset_us (rsp_chan.offset_us),
      .rsp_synced    (rsp_chan.synced)
   );

endmodule

// ----- tb/sv/tb_uart_time_offset_sync_receiver.sv -----
// Testbench for the UART time offset sync receiver: directed table plus framed random
// traffic, checked request by request against a built-in offset sync predictor.
// Depends on uts_pkg, uts_req_if / uts_rsp_if and the uart_time_offset_sync_receiver RTL.
`timescale 1ns / 100ps

module tb_uart_time_offset_sync_receiver;
   import uts_pkg::*;

   // Magic bytes in wire order, taken from the package constant.
   localparam logic [7:0] MAGIC_B0 = MAGIC_WORD[31:24];
   localparam logic [7:0] MAGIC_B1 = MAGIC_WORD[23:16];
   localparam logic [7:0] MAGIC_B2 = MAGIC_WORD[15:8];
   localparam logic [7:0] MAGIC_B3 = MAGIC_WORD[7:0];

   localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] T_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int unsigned NUM_PHASES     = 6;
   localparam int unsigned PHASE_BYTES    = 90;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned HOLD_AT        = 350;
   localparam int unsigned HOLD_CYCLES    = 100;
   localparam int unsigned STALL_LIMIT    = 4000;

   // One finished frame as the response channel reports it.
   typedef struct packed {
      event_type   ev;
      logic [7:0]  seq;
      logic [63:0] offset;
      logic        synced;
   } sync_result_type;

   // One received byte with its start-bit stamp.
   typedef struct packed {
      logic [7:0]  b;
      logic [63:0] t;
   } rx_item_type;

   // A row of the directed table. When typed is set, want is the response that the
   // row must produce; otherwise the predictor decides.
   typedef struct packed {
      logic [7:0]      b;
      logic [63:0]     t;
      logic            typed;
      sync_result_type want;
   } directed_row_type;

   localparam sync_result_type NO_RESULT = '{EV_MARKER, 8'h00, 64'd0, 1'b0};

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   uts_req_if req_link ();
   uts_rsp_if rsp_link ();

   uart_time_offset_sync_receiver u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_link),
      .rsp_chan  (rsp_link)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Predictor state. It mirrors the block's architectural state and is advanced once
   // per accepted request, in acceptance order.
   // ---------------------------------------------------------------------------------
   logic [15:0] payload_cap   = MAX_PAYLOAD_RESET;
   logic        want_request  = 1'b0;   // a marker has been taken, a request must follow
   logic [2:0]  hdr_count     = 3'd0;
   logic [63:0] hdr_bits      = 64'd0;  // header bytes, first byte in the top byte
   logic        in_body       = 1'b0;
   logic [15:0] body_left     = 16'd0;
   logic [63:0] body_word     = 64'd0;  // last eight payload bytes, little-endian
   logic [63:0] frame_t0      = 64'd0;  // stamp of the current frame's first byte
   logic [63:0] mark_time     = 64'd0;
   logic [7:0]  mark_seq      = 8'd0;
   logic [63:0] offset_now    = 64'd0;
   logic        is_synced     = 1'b0;

   sync_result_type expected_events[$];
   rx_item_type     frame_q[$];

   int unsigned fail_count  = 0;
   int unsigned bytes_taken = 0;
   int unsigned burst_left  = 0;
   bit          rsp_hold    = 1'b0;
   bit          hold_done   = 1'b0;

   // A frame whose header and payload have both been consumed. In the marker phase a
   // marker is latched and anything else is reported and dropped; in the request phase
   // the frame either completes the exchange or is rejected, and the block goes back
   // to waiting for a marker either way.
   function automatic bit close_frame(output sync_result_type res);
      logic [7:0]  ftype;
      logic [15:0] flen;
      logic [7:0]  fseq;
      ftype = hdr_bits[31:24];
      flen  = {hdr_bits[15:8], hdr_bits[23:16]};
      fseq  = hdr_bits[7:0];
      if (!want_request) begin
         if (ftype == TYPE_MARKER) begin
            mark_time    = frame_t0;
            mark_seq     = fseq;
            want_request = 1'b1;
            res = '{EV_MARKER, fseq, offset_now, is_synced};
         end else begin
            res = '{EV_OTHER, fseq, offset_now, is_synced};
         end
         return 1'b1;
      end
      want_request = 1'b0;
      if (ftype == TYPE_REQUEST && flen == REQUEST_LEN && fseq == mark_seq) begin
         // Wraps modulo 2^64 when t2 - t1 overflows.
         offset_now = mark_time - body_word;
         is_synced  = 1'b1;
         res = '{EV_OFFSET, fseq, offset_now, is_synced};
      end else begin
         res = '{EV_BAD_REQUEST, fseq, offset_now, is_synced};
      end
      return 1'b1;
   endfunction

   // Advances the predictor by one received byte. Returns 1 when the byte finishes a
   // frame and res holds the response it must cause.
   function automatic bit offset_sync_step(input logic [7:0] b, input logic [63:0] t,
                                           output sync_result_type res);
      logic [7:0]  fseq;
      logic [15:0] flen;
      res = NO_RESULT;
      if (in_body) begin
         body_word = {b, body_word[63:8]};
         body_left = body_left - 16'd1;
         if (body_left == 16'd0) begin
            in_body = 1'b0;
            return close_frame(res);
         end
         return 1'b0;
      end
      if (hdr_count == 3'd0) frame_t0 = t;
      hdr_bits = {hdr_bits[55:0], b};
      if (hdr_count != HEADER_LAST) begin
         hdr_count++;
         return 1'b0;
      end
      hdr_count = 3'd0;
      fseq = hdr_bits[7:0];
      flen = {hdr_bits[15:8], hdr_bits[23:16]};
      if (hdr_bits[63:32] != MAGIC_WORD) begin
         want_request = 1'b0;
         res = '{EV_BAD_MAGIC, fseq, offset_now, is_synced};
         return 1'b1;
      end
      // An oversized header does not skip its payload: those bytes are parsed as the
      // next header.
      if (flen > payload_cap) begin
         want_request = 1'b0;
         res = '{EV_TOO_LONG, fseq, offset_now, is_synced};
         return 1'b1;
      end
      body_word = 64'd0;
      if (flen == 16'd0) return close_frame(res);
      in_body   = 1'b1;
      body_left = flen;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------
   function automatic logic [63:0] pick_time();
      case ($urandom_range(0, 15))
         0:       return T_MAX;
         1:       return T_MIN;
         2:       return 64'd0;
         3:       return T_ALL;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void push_raw(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) frame_q.push_back('{8'($urandom), pick_time()});
   endfunction

   function automatic void push_header(input logic [7:0] kind, input logic [15:0] len,
                                       input logic [7:0] sq);
      frame_q.push_back('{MAGIC_B0, pick_time()});
      frame_q.push_back('{MAGIC_B1, pick_time()});
      frame_q.push_back('{MAGIC_B2, pick_time()});
      frame_q.push_back('{MAGIC_B3, pick_time()});
      frame_q.push_back('{kind, pick_time()});
      frame_q.push_back('{len[7:0], pick_time()});
      frame_q.push_back('{len[15:8], pick_time()});
      frame_q.push_back('{sq, pick_time()});
   endfunction

   // Queues the next frame. It is planned from the predictor's current state, so that
   // a stream knocked off its 8-byte alignment is padded back into step first and most
   // traffic is well-formed marker / request exchanges that reach the offset update.
   function automatic void plan_frame();
      int unsigned r;
      int unsigned idx;
      logic [15:0] len;
      logic [7:0]  sq;
      logic [7:0]  kind;
      logic [63:0] t1;
      if (in_body) push_raw(body_left);
      else if (hdr_count != 3'd0) push_raw(8 - hdr_count);
      r  = $urandom_range(0, 99);
      sq = 8'($urandom);
      if (r < 55) begin
         if (!want_request) begin
            // A marker, now and then carrying a payload that is skipped.
            len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 12)) : 16'd0;
            push_header(TYPE_MARKER, len, sq);
            push_raw(len);
         end else begin
            kind = TYPE_REQUEST;
            len  = REQUEST_LEN;
            sq   = mark_seq;
            case ($urandom_range(0, 9))
               0: sq   = mark_seq + 8'($urandom_range(1, 255));
               1: len  = 16'($urandom_range(0, 12));
               2: kind = TYPE_MARKER;  // a marker here is rejected, not taken
               3: kind = 8'($urandom);
               default: ;
            endcase
            push_header(kind, len, sq);
            if (len == REQUEST_LEN) begin
               t1 = pick_time();
               for (int i = 0; i < 8; i++) frame_q.push_back('{t1[8*i +: 8], pick_time()});
            end else begin
               push_raw(len);
            end
         end
      end else if (r < 67) begin
         // Frame of some other type, with a payload that may exceed eight bytes.
         len = 16'($urandom_range(0, 12));
         push_header(8'($urandom), len, sq);
         push_raw(len);
      end else if (r < 77) begin
         // Broken magic: one of the four magic bytes is flipped.
         push_header(8'($urandom), 16'($urandom_range(0, 12)), sq);
         idx = frame_q.size() - 8 + $urandom_range(0, 3);
         frame_q[idx].b = frame_q[idx].b ^ 8'($urandom_range(1, 255));
      end else if (r < 87 && payload_cap != 16'hFFFF) begin
         // Oversized length, just above the cap or anywhere above it.
         if ($urandom_range(0, 1) == 0) len = payload_cap + 16'd1;
         else len = 16'($urandom_range(payload_cap + 1, 16'hFFFF));
         push_header(8'($urandom), len, sq);
         push_raw($urandom_range(0, 3));
      end else begin
         // Line noise that shifts the byte alignment.
         push_raw($urandom_range(1, 7));
      end
   endfunction

   // Offers one request and returns at the edge that accepts it. The sender runs in
   // bursts; between bursts it may drop valid for a random gap, except while the
   // receiver is holding off, when it keeps pushing to fill the block.
   task automatic offer_byte(input logic [7:0] b, input logic [63:0] t, input logic typed,
                             input sync_result_type want);
      int unsigned gap;
      sync_result_type got;
      if (burst_left == 0) begin
         case ($urandom_range(0, 5))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(10, 24);
            default: gap = $urandom_range(1, 6);
         endcase
         if (rsp_hold) gap = 0;
         if (gap != 0) begin
            req_link.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 24);
      end
      burst_left--;
      req_link.valid        <= 1'b1;
      req_link.rx_byte      <= b;
      req_link.byte_time_us <= t;
      do @(posedge clock); while (req_link.ready !== 1'b1);
      bytes_taken++;
      if (offset_sync_step(b, t, got) && !typed) expected_events.push_back(got);
      if (typed) expected_events.push_back(want);
   endtask

   // Stops sending and waits until every expected response has come back, plus a settling
   // wait for a header still being parsed.
   task automatic settle();
      req_link.valid <= 1'b0;
      burst_left = 0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_payload_cap(input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      payload_cap = value;
   endtask

   // ---------------------------------------------------------------------------------
   // Directed table: a marker straight after reset carrying the largest stamp, a
   // request whose t1 is the most negative value so that the offset wraps to -1, and
   // a header with all-ones type and length, rejected as too long. The first byte of the
   // marker carries the stamp that matters; the other stamps are filler.
   // ---------------------------------------------------------------------------------
   directed_row_type directed_rows [0:31] = '{
      '{MAGIC_B0,     T_MAX, 1'b0, NO_RESULT},
      '{MAGIC_B1,     64'd1, 1'b0, NO_RESULT},
      '{MAGIC_B2,     64'd2, 1'b0, NO_RESULT},
      '{MAGIC_B3,     64'd3, 1'b0, NO_RESULT},
      '{TYPE_MARKER,  64'd4, 1'b0, NO_RESULT},
      '{8'h00,        64'd5, 1'b0, NO_RESULT},
      '{8'h00,        64'd6, 1'b0, NO_RESULT},
      '{8'hFF,        64'd7, 1'b1, '{EV_MARKER, 8'hFF, 64'd0, 1'b0}},
      '{MAGIC_B0,     T_MIN, 1'b0, NO_RESULT},
      '{MAGIC_B1,     T_ALL, 1'b0, NO_RESULT},
      '{MAGIC_B2,     T_MAX, 1'b0, NO_RESULT},
      '{MAGIC_B3,     64'd0, 1'b0, NO_RESULT},
      '{TYPE_REQUEST, 64'd0, 1'b0, NO_RESULT},
      '{8'd8,         64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b0, NO_RESULT},
      '{8'hFF,        64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b0, NO_RESULT},
      '{8'h80,        64'd0, 1'b1, '{EV_OFFSET, 8'hFF, T_ALL, 1'b1}},
      '{MAGIC_B0,     64'h0123_4567_89AB_CDEF, 1'b0, NO_RESULT},
      '{MAGIC_B1,     64'd0, 1'b0, NO_RESULT},
      '{MAGIC_B2,     64'd0, 1'b0, NO_RESULT},
      '{MAGIC_B3,     64'd0, 1'b0, NO_RESULT},
      '{8'hFF,        64'd0, 1'b0, NO_RESULT},
      '{8'hFF,        64'd0, 1'b0, NO_RESULT},
      '{8'hFF,        64'd0, 1'b0, NO_RESULT},
      '{8'h00,        64'd0, 1'b1, '{EV_TOO_LONG, 8'h00, T_ALL, 1'b1}}
   };

   // ---------------------------------------------------------------------------------
   // Main sequence: reset, the directed table, then framed random phases under
   // different payload caps, including both extremes. The cap is only changed once
   // the block has drained.
   // ---------------------------------------------------------------------------------
   initial begin : request_driver
      logic [15:0] phase_cap [NUM_PHASES];
      int unsigned sent;
      rx_item_type item;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_wdata             = 16'd0;
      req_link.valid        = 1'b0;
      req_link.rx_byte      = 8'd0;
      req_link.byte_time_us = 64'd0;
      phase_cap = '{MAX_PAYLOAD_RESET, 16'd0, 16'hFFFF, 16'd8, 16'd0, MAX_PAYLOAD_RESET};
      phase_cap[4] = 16'($urandom_range(9, 16'hFFFE));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(directed_rows); i++) begin
         offer_byte(directed_rows[i].b, directed_rows[i].t, directed_rows[i].typed,
                    directed_rows[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            settle();
            write_payload_cap(phase_cap[p]);
         end
         sent = 0;
         while (sent < PHASE_BYTES || frame_q.size() != 0) begin
            if (frame_q.size() == 0) plan_frame();
            item = frame_q.pop_front();
            offer_byte(item.b, item.t, 1'b0, NO_RESULT);
            sent++;
            // Once in the middle of a phase the sender pauses until the block is empty.
            if (p == 2 && sent == PHASE_BYTES / 2) settle();
         end
      end

      settle();
      if (fail_count == 0 && expected_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Response side. Ready follows a pattern whose style is picked at random:
   // always ready, mostly ready, one cycle in four, and mostly stalled. Once, a long
   // hold-off lets the internal frame queue fill so that the block must stall its
   // request channel.
   // ---------------------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      int unsigned tick;
      int unsigned style;
      logic        take;
      rsp_link.ready = 1'b0;
      tick  = 0;
      style = 0;
      forever begin
         @(posedge clock);
         if (!hold_done && bytes_taken >= HOLD_AT) begin
            rsp_hold = 1'b1;
            rsp_link.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold  = 1'b0;
            hold_done = 1'b1;
         end else begin
            if (tick % 48 == 0) style = $urandom_range(0, 3);
            tick++;
            case (style)
               0:       take = 1'b1;
               1:       take = ($urandom_range(0, 9) < 7);
               2:       take = (tick % 4 == 0);
               default: take = ($urandom_range(0, 9) < 3);
            endcase
            rsp_link.ready <= take;
         end
      end
   end

   // Every accepted response is checked against the oldest expectation, field by field.
   always @(posedge clock) begin : rsp_checker
      sync_result_type want;
      if (reset === 1'b0 && rsp_link.valid === 1'b1 && rsp_link.ready === 1'b1) begin
         if (expected_events.size() == 0) begin
            $error("response with nothing expected: event_res %0d frame_seq 0x%02h",
                   rsp_link.event_res, rsp_link.frame_seq);
            fail_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_link.event_res !== want.ev) begin
               $error("event_res: expected %0d, got %0d", want.ev, rsp_link.event_res);
               fail_count++;
            end
            if (rsp_link.frame_seq !== want.seq) begin
               $error("frame_seq: expected 0x%02h, got 0x%02h", want.seq,
                      rsp_link.frame_seq);
               fail_count++;
            end
            if (rsp_link.offset_us !== want.offset) begin
               $error("offset_us: expected 0x%016h, got 0x%016h", want.offset,
                      rsp_link.offset_us);
               fail_count++;
            end
            if (rsp_link.synced !== want.synced) begin
               $error("synced: expected %0b, got %0b", want.synced, rsp_link.synced);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when no request or response has moved for too long.
   initial begin : stall_watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_link.valid === 1'b1 && req_link.ready === 1'b1) ||
             (rsp_link.valid === 1'b1 && rsp_link.ready === 1'b1)) quiet = 0;
         else quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

endmodule
